// ----- rtl/core/nf_chain_action_consolidator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// nf_chain_action_consolidator_unit_assert
// Assertion macros for the action consolidator.
// ----------------------------------------------------------------------------
`ifndef NF_CHAIN_ACTION_CONSOLIDATOR_UNIT_ASSERT_SVH
`define NF_CHAIN_ACTION_CONSOLIDATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/nfc_pkg.sv -----
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared types and constants of the action consolidator.
// ----------------------------------------------------------------------------
package nfc_pkg;
  localparam int unsigned NfCount    = 4;
  localparam int unsigned FlowCount  = 1024;
  localparam int unsigned NfW        = (NfCount > 1) ? $clog2(NfCount) : 1;
  localparam int unsigned FlowW      = (FlowCount > 1) ? $clog2(FlowCount) : 1;
  localparam int unsigned LocalDepth = NfCount * FlowCount;
  localparam int unsigned LocalAw    = (LocalDepth > 1) ? $clog2(LocalDepth) : 1;
  localparam int unsigned LocalW     = 36;
  localparam int unsigned UpdW       = 68;
  // global entry: {valid, drop, four values}
  localparam int unsigned GlobW      = 130;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0, ACT_REG = 2'd1, ACT_CHECK = 2'd2, ACT_READ = 2'd3
  } action_e;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindDrop = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_UPD_RD, ST_UPD_EV, ST_MRG_RD, ST_MRG_ACC, ST_GL_WR,
    ST_GL_RD, ST_GL_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  nf_index;
    logic [9:0]  flow_index;
    logic [1:0]  rule_action;
    logic [1:0]  rule_field;
    logic [31:0] rule_value;
    logic [31:0] threshold;
    logic [31:0] state_value;
  } req_t;

  typedef struct packed {
    logic        is_drop;
    logic        rule_present;
    logic [31:0] value_src_ip;
    logic [31:0] value_src_port;
    logic [31:0] value_dst_ip;
    logic [31:0] value_dst_port;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic cap_req;     // latch request
    logic clr_wr;      // write clear sweep entry
    logic clr_adv;     // advance sweep counter
    logic upd_rd;      // read update rule
    logic upd_eval;    // apply update if due
    logic loc_rd;      // read local entry of current nf
    logic acc;         // merge read entry
    logic acc_clr;     // reset merge accumulator and nf counter
    logic nf_adv;      // advance nf counter
    logic gl_wr;       // write rule: local (add), update (register), merged global (check)
    logic gl_rd;       // read global rule
    logic out_en;      // drive result
  } cmd_t;

  typedef struct packed {
    logic     clr_last;
    logic     nf_last;
    logic     flow_ok;
    action_e  action;
  } sts_t;
endpackage

// ----- rtl/core/nf_chain_action_consolidator_unit.sv -----
// ----------------------------------------------------------------------------
// nf_chain_action_consolidator_unit
// Per-flow rule merge over a chain of network functions.
// ----------------------------------------------------------------------------
// Each accepted add, register, read or check ends in the done strobe; one
// transaction at a time, the next one accepted in the cycle after the strobe
// at the earliest.
// The merge walks one local entry per function through the local RAM port.
// After reset the local, done and global tables are swept to zero, with busy
// high, over NF_COUNT*FLOW_COUNT (4096) local addresses; the receiver cannot stall.
module nf_chain_action_consolidator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  nfc_pkg::req_t req_i,
  output logic          done_o,
  output nfc_pkg::rsp_t rsp_o
);
  import nfc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each transaction through the tables.
  nfc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd)
  );

  // Hold tables, merge, and drive the result for one cycle.
  nfc_dp u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts),
    .rsp_valid_o(done_o), .rsp_o
  );
endmodule

// ----- rtl/core/nfc_ram.sv -----
// ----------------------------------------------------------------------------
// nfc_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module nfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- rtl/core/nfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nfc_ctrl
// Sequencer of the action consolidator.
// ----------------------------------------------------------------------------
`include "nf_chain_action_consolidator_unit_assert.svh"
module nfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  nfc_pkg::sts_t sts_i,
  output nfc_pkg::cmd_t cmd_o
);
  import nfc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:    if (start_i) state_d = ST_UPD_RD;
      ST_UPD_RD: begin
        // request is latched now; branch on it
        if (!sts_i.flow_ok) state_d = ST_GL_OUT;
        else if (sts_i.action == ACT_CHECK) state_d = ST_UPD_EV;
        else if (sts_i.action == ACT_READ) state_d = ST_GL_RD;
        else state_d = ST_GL_WR;
      end
      ST_UPD_EV:  state_d = ST_MRG_RD;
      ST_MRG_RD:  state_d = ST_MRG_ACC;
      ST_MRG_ACC: state_d = sts_i.nf_last ? ST_GL_WR : ST_MRG_RD;
      ST_GL_WR:   state_d = ST_GL_RD;
      ST_GL_RD:   state_d = ST_GL_OUT;
      ST_GL_OUT:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.clr_adv = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.cap_req = start_i;
      end
      ST_UPD_RD: begin
        cmd_o.upd_rd  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_UPD_EV:  cmd_o.upd_eval = 1'b1;
      ST_MRG_RD:  cmd_o.loc_rd = 1'b1;
      ST_MRG_ACC: begin
        cmd_o.acc    = 1'b1;
        cmd_o.nf_adv = 1'b1;
      end
      ST_GL_WR:   cmd_o.gl_wr = 1'b1;
      ST_GL_RD:   cmd_o.gl_rd = 1'b1;
      ST_GL_OUT:  cmd_o.out_en = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  `NFC_ASSERT_NXT(a_start_leaves_idle, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `NFC_ASSERT_NXT(a_out_then_idle, clk_i, rst_ni, cmd_o.out_en, !busy_o)
  `NFC_ASSERT_IMP(a_gl_wr_only_flow_ok, clk_i, rst_ni, cmd_o.gl_wr, sts_i.flow_ok)
endmodule

// ----- rtl/core/nfc_dp.sv -----
// ----------------------------------------------------------------------------
// nfc_dp
// Rule tables, update logic and merge accumulator.
// ----------------------------------------------------------------------------
`include "nf_chain_action_consolidator_unit_assert.svh"
module nfc_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nfc_pkg::req_t req_i,
  input  nfc_pkg::cmd_t cmd_i,
  output nfc_pkg::sts_t sts_o,
  output logic          rsp_valid_o,
  output nfc_pkg::rsp_t rsp_o
);
  import nfc_pkg::*;

  localparam int unsigned ClrW = LocalAw + 1;

  req_t             req_q;
  logic [ClrW-1:0]  clr_q;
  logic [NfW-1:0]   nf_q;
  logic [FlowW-1:0] flow;
  logic             flow_ok, nf_ok;

  // local table, packed {kind, field, value}
  logic               loc_we;
  logic [LocalAw-1:0] loc_waddr, loc_raddr;
  logic [LocalW-1:0]  loc_wdata, loc_rdata;
  // update table {threshold, kind, field, value}
  logic [UpdW-1:0]    upd_rdata;
  // per-flow done bits and global rules, swept to zero after reset
  logic               clr_flow;
  logic [FlowW-1:0]   fl_waddr;
  logic               done_we, done_wdata, done_rdata;
  logic               gl_we;
  logic [GlobW-1:0]   gl_wdata, gl_rdata;

  logic         drop_q;
  logic [31:0]  val_q [4];
  logic         fire;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) req_q <= req_i;
  end

  assign flow    = req_q.flow_index[FlowW-1:0];
  assign flow_ok = ({22'd0, req_q.flow_index} < 32'(FlowCount));
  assign nf_ok   = ({30'd0, req_q.nf_index} < 32'(NfCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_adv) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q <= '0;
    end else if (cmd_i.acc_clr) begin
      nf_q <= '0;
    end else if (cmd_i.nf_adv) begin
      nf_q <= (sts_o.nf_last) ? '0 : nf_q + 1'b1;
    end
  end

  // update applies when not done and state > threshold
  assign fire = cmd_i.upd_eval && nf_ok && !done_rdata &&
                ($signed(req_q.state_value) > $signed(upd_rdata[67:36]));

  always_comb begin
    loc_we    = 1'b0;
    loc_waddr = LocalAw'(32'(req_q.nf_index) * FlowCount + 32'(flow));
    loc_wdata = {req_q.rule_action, req_q.rule_field, req_q.rule_value};
    if (cmd_i.clr_wr) begin
      loc_we    = 1'b1;
      loc_waddr = clr_q[LocalAw-1:0];
      loc_wdata = '0;
    end else if (cmd_i.gl_wr && req_q.action == ACT_ADD && nf_ok) begin
      loc_we = 1'b1;
    end else if (fire) begin
      loc_we    = 1'b1;
      loc_wdata = upd_rdata[35:0];
    end
  end

  assign loc_raddr = LocalAw'(32'(nf_q) * FlowCount + 32'(flow));

  nfc_ram #(.Width(LocalW), .Depth(LocalDepth)) u_local (
    .clk_i, .we_i(loc_we), .waddr_i(loc_waddr), .wdata_i(loc_wdata),
    .re_i(cmd_i.loc_rd), .raddr_i(loc_raddr), .rdata_o(loc_rdata)
  );

  nfc_ram #(.Width(UpdW), .Depth(FlowCount)) u_upd (
    .clk_i,
    .we_i(cmd_i.gl_wr && req_q.action == ACT_REG),
    .waddr_i(flow),
    .wdata_i({req_q.threshold, req_q.rule_action, req_q.rule_field, req_q.rule_value}),
    .re_i(cmd_i.upd_rd), .raddr_i(flow), .rdata_o(upd_rdata)
  );

  // the sweep also zeroes the per-flow tables on its first FlowCount steps
  assign clr_flow = cmd_i.clr_wr && (clr_q < ClrW'(FlowCount));
  assign fl_waddr = cmd_i.clr_wr ? clr_q[FlowW-1:0] : flow;

  assign done_we    = clr_flow || fire;
  assign done_wdata = fire;

  nfc_ram #(.Width(1), .Depth(FlowCount)) u_done (
    .clk_i, .we_i(done_we), .waddr_i(fl_waddr), .wdata_i(done_wdata),
    .re_i(cmd_i.upd_rd), .raddr_i(flow), .rdata_o(done_rdata)
  );

  // merge accumulator; sticky drop zeroes values on write
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      drop_q <= 1'b0;
      for (int i = 0; i < 4; i++) val_q[i] <= '0;
    end else if (cmd_i.acc && !drop_q) begin
      if (loc_rdata[35:34] == KindDrop) begin
        drop_q <= 1'b1;
      end else if (loc_rdata[35:34] != KindNone) begin
        val_q[loc_rdata[33:32]] <= loc_rdata[31:0];
      end
    end
  end

  always_comb begin
    if (cmd_i.clr_wr) begin
      gl_wdata = '0;
    end else if (drop_q) begin
      gl_wdata = {2'b11, 128'd0};
    end else begin
      gl_wdata = {2'b10, val_q[0], val_q[1], val_q[2], val_q[3]};
    end
  end

  assign gl_we = clr_flow || (cmd_i.gl_wr && req_q.action == ACT_CHECK);

  nfc_ram #(.Width(GlobW), .Depth(FlowCount)) u_glob (
    .clk_i, .we_i(gl_we), .waddr_i(fl_waddr),
    .wdata_i(gl_wdata), .re_i(cmd_i.gl_rd), .raddr_i(flow), .rdata_o(gl_rdata)
  );

  always_comb begin
    rsp_o = '0;
    if (flow_ok) begin
      rsp_o.rule_present   = gl_rdata[129];
      rsp_o.is_drop        = gl_rdata[128];
      rsp_o.value_src_ip   = gl_rdata[127:96];
      rsp_o.value_src_port = gl_rdata[95:64];
      rsp_o.value_dst_ip   = gl_rdata[63:32];
      rsp_o.value_dst_port = gl_rdata[31:0];
    end
  end
  assign rsp_valid_o = cmd_i.out_en;

  assign sts_o.clr_last = (clr_q == ClrW'(LocalDepth - 1));
  assign sts_o.nf_last  = (nf_q == NfW'(NfCount - 1));
  assign sts_o.flow_ok  = flow_ok;
  assign sts_o.action   = action_e'(req_q.action);

  `NFC_ASSERT_IMP(a_fire_in_eval, clk_i, rst_ni, fire, cmd_i.upd_eval && nf_ok)
  `NFC_ASSERT_IMP(a_clr_alone, clk_i, rst_ni, cmd_i.clr_wr, !cmd_i.gl_wr && !fire)
  `NFC_ASSERT_IMP(a_drop_zero, clk_i, rst_ni, rsp_valid_o && rsp_o.is_drop,
                  rsp_o.value_src_ip == 32'd0 && rsp_o.value_dst_port == 32'd0)
endmodule
